/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files that carry concurrent checks.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequent that holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequent that holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/iied_pkg.sv */
// Package for the IN/OUT exit-info decoder: payload types, decode state,
// prefix and opcode constants and the mode default function. No dependencies.
package iied_pkg;

  localparam int MAX_LENGTH = 15;

  localparam logic [1:0] MODE_LONG     = 2'd0;
  localparam logic [1:0] MODE_COMPAT32 = 2'd1;
  localparam logic [1:0] MODE_COMPAT16 = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  localparam logic [7:0] PFX_ES      = 8'h26;
  localparam logic [7:0] PFX_CS      = 8'h2E;
  localparam logic [7:0] PFX_SS      = 8'h36;
  localparam logic [7:0] PFX_DS      = 8'h3E;
  localparam logic [7:0] PFX_FS      = 8'h64;
  localparam logic [7:0] PFX_LOCK    = 8'hF0;
  localparam logic [7:0] PFX_OPSIZE  = 8'h66;
  localparam logic [7:0] PFX_ADSIZE  = 8'h67;
  localparam logic [7:0] PFX_REPNE   = 8'hF2;
  localparam logic [7:0] PFX_REP     = 8'hF3;
  localparam logic [3:0] REX_HIGH    = 4'h4;
  localparam logic [7:0] OP_IMM_LOW  = 8'hE4;
  localparam logic [7:0] OP_IMM_HIGH = 8'hE7;
  localparam logic [7:0] OP_DX_LOW   = 8'hEC;
  localparam logic [7:0] OP_DX_HIGH  = 8'hEF;

  localparam int INFO_IN    = 0;
  localparam int INFO_REP   = 3;
  localparam int INFO_SZ8   = 4;
  localparam int INFO_SZ16  = 5;
  localparam int INFO_SZ32  = 6;
  localparam int INFO_A16   = 7;
  localparam int INFO_A32   = 8;
  localparam int INFO_A64   = 9;
  localparam int INFO_PORT  = 16;

  typedef struct packed {
    logic [7:0]  code_byte;
    logic [15:0] dx_port;
  } item_t;

  typedef struct packed {
    logic [31:0] exit_info;
    logic [3:0]  instruction_length;
    logic        supported;
  } result_t;

  typedef struct packed {
    logic       await_immediate;
    logic [1:0] data_size_code;
    logic [1:0] addr_size_code;
    logic       rex_seen;
    logic       rep_seen;
    logic [1:0] held_opcode;
    logic [3:0] prefix_count;
  } dec_state_t;

  function automatic dec_state_t start_state(input logic [1:0] mode);
    dec_state_t s;
    s = '0;
    unique case (mode)
      MODE_COMPAT32: begin
        s.data_size_code = SIZE_32;
        s.addr_size_code = SIZE_32;
      end
      MODE_COMPAT16: begin
        s.data_size_code = SIZE_16;
        s.addr_size_code = SIZE_16;
      end
      default: begin
        s.data_size_code = SIZE_32;
        s.addr_size_code = SIZE_64;
      end
    endcase
    return s;
  endfunction

endpackage

/* hw/rtl/iied_decoder.sv */
// Byte decoder of the IN/OUT exit-info decoder: mode register, prefix state
// and the combinational result of one byte. Depends on iied_pkg.
module iied_decoder (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_data,
  input  logic             step,
  input  iied_pkg::item_t  item,
  output logic             res_valid,
  output iied_pkg::result_t res
);
  import iied_pkg::*;

  logic [1:0] mode;
  dec_state_t state;
  dec_state_t state_next;
  logic       long_mode;
  logic [7:0] b;
  logic [3:0] count_inc;

  function automatic logic [31:0] build_info(input dec_state_t s, input logic [1:0] op,
                                             input logic [15:0] port);
    logic [31:0] info;
    info = '0;
    info[INFO_IN] = ~op[1];
    if (!op[0]) begin
      info[INFO_SZ8] = 1'b1;
    end else if (s.data_size_code == SIZE_16) begin
      info[INFO_SZ16] = 1'b1;
    end else begin
      info[INFO_SZ32] = 1'b1;
    end
    info[INFO_A16] = (s.addr_size_code == SIZE_16);
    info[INFO_A32] = (s.addr_size_code == SIZE_32);
    info[INFO_A64] = (s.addr_size_code == SIZE_64);
    info[INFO_REP] = s.rep_seen;
    info[INFO_PORT +: 16] = port;
    return info;
  endfunction

  function automatic logic [3:0] length_of(input logic [3:0] count, input logic [1:0] body);
    logic [4:0] len;
    len = {1'b0, count} + {3'b0, body};
    if (len > 5'(MAX_LENGTH)) begin
      len = 5'(MAX_LENGTH);
    end
    return len[3:0];
  endfunction

  assign b         = item.code_byte;
  assign long_mode = (mode == MODE_LONG) || (mode == MODE_RESERVED);
  assign count_inc = (state.prefix_count == 4'hF) ? state.prefix_count
                                                  : state.prefix_count + 4'd1;

  always_comb begin
    state_next = state;
    res_valid  = 1'b0;
    res        = '0;
    priority if (state.await_immediate) begin
      res_valid              = 1'b1;
      res.exit_info          = build_info(state, state.held_opcode, {8'h00, b});
      res.instruction_length = length_of(state.prefix_count, 2'd2);
      res.supported          = 1'b1;
      state_next             = start_state(mode);
    end else if (b == PFX_ES || b == PFX_CS || b == PFX_SS || b == PFX_DS ||
                 b == PFX_FS || b == PFX_LOCK) begin
      state_next.prefix_count = count_inc;
    end else if (long_mode && b[7:4] == REX_HIGH) begin
      state_next.rex_seen     = 1'b1;
      if (b[3]) begin
        state_next.data_size_code = SIZE_64;
      end
      state_next.prefix_count = count_inc;
    end else if (b == PFX_OPSIZE) begin
      if (!state.rex_seen) begin
        state_next.data_size_code = (mode == MODE_COMPAT16) ? SIZE_32 : SIZE_16;
      end
      state_next.prefix_count = count_inc;
    end else if (b == PFX_ADSIZE) begin
      state_next.addr_size_code = (mode == MODE_COMPAT32) ? SIZE_16 : SIZE_32;
      state_next.prefix_count   = count_inc;
    end else if (b == PFX_REPNE || b == PFX_REP) begin
      state_next.rep_seen     = 1'b1;
      state_next.prefix_count = count_inc;
    end else if (b >= OP_IMM_LOW && b <= OP_IMM_HIGH) begin
      state_next.held_opcode     = b[1:0];
      state_next.await_immediate = 1'b1;
    end else if (b >= OP_DX_LOW && b <= OP_DX_HIGH) begin
      res_valid              = 1'b1;
      res.exit_info          = build_info(state, b[1:0], item.dx_port);
      res.instruction_length = length_of(state.prefix_count, 2'd1);
      res.supported          = 1'b1;
      state_next             = start_state(mode);
    end else begin
      res_valid              = 1'b1;
      res.instruction_length = length_of(state.prefix_count, 2'd1);
      state_next             = start_state(mode);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_LONG;
      state <= start_state(MODE_LONG);
    end else if (cfg_we) begin
      mode  <= cfg_data;
      state <= start_state(cfg_data);
    end else if (step) begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/iied_out_reg.sv */
// Result register of the IN/OUT exit-info decoder, holding one transaction
// until the receiver takes it. Depends on iied_pkg.
module iied_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  iied_pkg::result_t load_data,
  input  logic              result_stall,
  output logic              free,
  output logic              result_valid,
  output iied_pkg::result_t result
);
  import iied_pkg::*;

  logic result_valid_next;

  assign free = !result_valid || !result_stall;

  always_comb begin
    result_valid_next = result_valid;
    if (load) begin
      result_valid_next = 1'b1;
    end else if (!result_stall) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= load_data;
    end
  end

endmodule

/* hw/rtl/io_instruction_exit_info_decoder.sv */
// Top level of the IN/OUT exit-info decoder: input register, byte decoder
// and result register. Depends on iied_pkg, iied_decoder, iied_out_reg and assert_macros.svh.
//
// Instruction bytes arrive on the item channel (item_valid, item_stall, item),
// one transaction per byte, each with the current DX value. Prefix bytes and
// the opcode of an imm8 form produce no result; the final byte of an
// instruction produces one transaction on the result channel (result_valid,
// result_stall, result) carrying the exit-info word, the length and the
// supported flag.
// A byte is registered in the input register on acceptance and is decoded once the
// result register is free; the decoded result is loaded into the result register,
// which raises result_valid. One byte is accepted every cycle while the result
// register is free or being emptied.
// When the receiver stalls with a result waiting, the input register holds
// its byte and item_stall rises until the result is taken.
// The mode register is written through cfg_valid, cfg_ready and cfg_data; the user must
// write it only while the block is idle, which the block does not enforce. A write
// restarts decoding with that mode's sizes; reset empties both registers and restarts in long mode.
module io_instruction_exit_info_decoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  iied_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output iied_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data
);
  import iied_pkg::*;
  `include "assert_macros.svh"

  logic    held_valid;
  logic    held_valid_next;
  item_t   held_item;
  logic    out_free;
  logic    step;
  logic    accept;
  logic    dec_valid;
  result_t dec_result;

  assign cfg_ready  = 1'b1;
  assign step       = held_valid && out_free;
  assign item_stall = held_valid && !out_free;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    held_valid_next = held_valid;
    if (accept) begin
      held_valid_next = 1'b1;
    end else if (step) begin
      held_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_item <= item;
    end
  end

  iied_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (held_item),
    .res_valid (dec_valid),
    .res       (dec_result)
  );

  iied_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (step && dec_valid),
    .load_data    (dec_result),
    .result_stall (result_stall),
    .free         (out_free),
    .result_valid (result_valid),
    .result       (result)
  );

  `ASSERT_IMPLIES(a_unsupported_zero, result_valid && !result.supported, result.exit_info == 32'h0, "unsupported result carries a non-zero word")
  `ASSERT_IMPLIES(a_length_range, result_valid, result.instruction_length != 4'h0 && 32'(result.instruction_length) <= MAX_LENGTH, "instruction length out of range")
  `ASSERT_IMPLIES(a_sizes_onehot, result_valid && result.supported, $onehot(result.exit_info[6:4]) && $onehot(result.exit_info[9:7]), "size fields not one-hot")
  `ASSERT_NEXT(a_held_until_step, held_valid && !out_free, held_valid && $stable(held_item), "held byte lost while stalled")

endmodule

/* dv/tb_io_instruction_exit_info_decoder.sv */
// Self-checking testbench for io_instruction_exit_info_decoder: a directed table, then random
// instruction streams in every CPU mode, checked against a byte-level decode predictor.
// Depends on iied_pkg and the RTL of the decoder only.
`timescale 1ns / 100ps

module tb_io_instruction_exit_info_decoder;
  import iied_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int ITEMS_PER_MODE = 215;
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    logic       await_imm;
    logic [1:0] dsz;
    logic [1:0] asz;
    logic       rex;
    logic       rep;
    logic [7:0] op;
    logic [3:0] npfx;
  } decode_t;

  typedef struct {
    logic [7:0]  code;
    logic [15:0] dx;
    bit          fixed;
    result_t     want;
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = MODE_LONG;

  logic [1:0] mode_q;
  decode_t dec;
  result_t expected_exits[$];
  int mismatches = 0;
  int results_taken = 0;
  int rx_pause = 0;
  int items_sent = 0;
  int cycles = 0;
  bit calm_tx = 1'b0;
  bit calm_rx = 1'b0;

  logic [1:0] mode_plan [6] = '{MODE_LONG, MODE_COMPAT32, MODE_COMPAT16, MODE_RESERVED,
                                MODE_COMPAT32, MODE_LONG};

  logic [7:0] prefix_set [10] = '{PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_LOCK,
                                  PFX_OPSIZE, PFX_ADSIZE, PFX_REPNE, PFX_REP};

  vector_t plan [28] = '{
    '{OP_DX_LOW, 16'h0000, 1'b1, '{32'h0000_0211, 4'd1, 1'b1}},
    '{OP_DX_HIGH, 16'hFFFF, 1'b1, '{32'hFFFF_0240, 4'd1, 1'b1}},
    '{8'h00, 16'h0000, 1'b1, '{32'h0000_0000, 4'd1, 1'b0}},
    '{8'hFF, 16'hFFFF, 1'b1, '{32'h0000_0000, 4'd1, 1'b0}},
    '{OP_IMM_LOW, 16'h1234, 1'b0, '0},
    '{8'hFF, 16'h1234, 1'b1, '{32'h00FF_0211, 4'd2, 1'b1}},
    '{OP_IMM_HIGH, 16'h0000, 1'b0, '0},
    '{8'h00, 16'hFFFF, 1'b1, '{32'h0000_0240, 4'd2, 1'b1}},
    '{PFX_OPSIZE, 16'h0000, 1'b0, '0},
    '{OP_DX_LOW + 8'd1, 16'h8001, 1'b0, '0},
    '{{REX_HIGH, 4'h8}, 16'h0000, 1'b0, '0},
    '{PFX_OPSIZE, 16'h0000, 1'b0, '0},
    '{OP_IMM_LOW + 8'd1, 16'h0000, 1'b0, '0},
    '{OP_DX_LOW, 16'h0000, 1'b0, '0},
    '{PFX_ADSIZE, 16'h0000, 1'b0, '0},
    '{PFX_REP, 16'h0000, 1'b0, '0},
    '{OP_DX_HIGH - 8'd1, 16'h5555, 1'b0, '0},
    '{PFX_ES, 16'h0000, 1'b0, '0},
    '{PFX_CS, 16'h0000, 1'b0, '0},
    '{PFX_SS, 16'h0000, 1'b0, '0},
    '{PFX_DS, 16'h0000, 1'b0, '0},
    '{PFX_FS, 16'h0000, 1'b0, '0},
    '{PFX_LOCK, 16'h0000, 1'b0, '0},
    '{PFX_REPNE, 16'h0000, 1'b0, '0},
    '{OP_IMM_HIGH - 8'd1, 16'hAAAA, 1'b0, '0},
    '{8'hAA, 16'h0000, 1'b0, '0},
    '{{REX_HIGH, 4'h1}, 16'h0000, 1'b0, '0},
    '{8'h90, 16'h0000, 1'b0, '0}
  };

  io_instruction_exit_info_decoder dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic decode_t restart(input logic [1:0] m);
    decode_t d;
    d = '0;
    case (m)
      MODE_COMPAT32: begin
        d.dsz = SIZE_32;
        d.asz = SIZE_32;
      end
      MODE_COMPAT16: begin
        d.dsz = SIZE_16;
        d.asz = SIZE_16;
      end
      default: begin
        d.dsz = SIZE_32;
        d.asz = SIZE_64;
      end
    endcase
    return d;
  endfunction

  function automatic logic [31:0] io_info(input logic [7:0] op, input logic [15:0] port,
                                          input decode_t d);
    logic [31:0] w;
    w = '0;
    w[INFO_IN] = ~op[1];
    if (!op[0]) begin
      w[INFO_SZ8] = 1'b1;
    end else if (d.dsz == SIZE_16) begin
      w[INFO_SZ16] = 1'b1;
    end else begin
      w[INFO_SZ32] = 1'b1;
    end
    case (d.asz)
      SIZE_16: w[INFO_A16] = 1'b1;
      SIZE_32: w[INFO_A32] = 1'b1;
      SIZE_64: w[INFO_A64] = 1'b1;
      default: ;
    endcase
    w[INFO_REP] = d.rep;
    w[31:INFO_PORT] = port;
    return w;
  endfunction

  function automatic logic [3:0] length_with(input int body);
    int n;
    n = dec.npfx + body;
    if (n > MAX_LENGTH) n = MAX_LENGTH;
    return n[3:0];
  endfunction

  function automatic void count_prefix();
    if (dec.npfx < 4'd15) dec.npfx = dec.npfx + 4'd1;
  endfunction

  // Advances the decode state by one byte; returns 1 when the byte ends an instruction.
  function automatic bit decode_byte(input item_t it, output result_t r);
    logic [7:0] b;
    logic long_mode;
    b = it.code_byte;
    long_mode = (mode_q == MODE_LONG) || (mode_q == MODE_RESERVED);
    r = '0;
    if (dec.await_imm) begin
      r.exit_info = io_info(dec.op, {8'h00, b}, dec);
      r.instruction_length = length_with(2);
      r.supported = 1'b1;
      dec = restart(mode_q);
      return 1'b1;
    end
    if (b inside {PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_LOCK}) begin
      count_prefix();
      return 1'b0;
    end
    if (long_mode && b[7:4] == REX_HIGH) begin
      dec.rex = 1'b1;
      if (b[3]) dec.dsz = SIZE_64;
      count_prefix();
      return 1'b0;
    end
    if (b == PFX_OPSIZE) begin
      if (!dec.rex) dec.dsz = (mode_q == MODE_COMPAT16) ? SIZE_32 : SIZE_16;
      count_prefix();
      return 1'b0;
    end
    if (b == PFX_ADSIZE) begin
      dec.asz = (mode_q == MODE_COMPAT32) ? SIZE_16 : SIZE_32;
      count_prefix();
      return 1'b0;
    end
    if (b == PFX_REPNE || b == PFX_REP) begin
      dec.rep = 1'b1;
      count_prefix();
      return 1'b0;
    end
    if (b >= OP_IMM_LOW && b <= OP_IMM_HIGH) begin
      dec.op = b;
      dec.await_imm = 1'b1;
      return 1'b0;
    end
    if (b >= OP_DX_LOW && b <= OP_DX_HIGH) begin
      r.exit_info = io_info(b, it.dx_port, dec);
      r.supported = 1'b1;
    end
    r.instruction_length = length_with(1);
    dec = restart(mode_q);
    return 1'b1;
  endfunction

  task automatic check_exit(input result_t got);
    result_t want;
    if (expected_exits.size() == 0) begin
      $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
      mismatches++;
    end else begin
      want = expected_exits.pop_front();
      if (got.exit_info !== want.exit_info) begin
        $display("%0t: exit_info expected %h actual %h", $time, want.exit_info, got.exit_info);
        mismatches++;
      end
      if (got.instruction_length !== want.instruction_length) begin
        $display("%0t: instruction_length expected %0d actual %0d", $time,
                 want.instruction_length, got.instruction_length);
        mismatches++;
      end
      if (got.supported !== want.supported) begin
        $display("%0t: supported expected %b actual %b", $time, want.supported, got.supported);
        mismatches++;
      end
    end
  endtask

  // Receiver: random stalls between transactions, with two long holds to fill the block.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        check_exit(result);
        results_taken++;
        if ($urandom_range(0, 39) == 0) calm_rx = ~calm_rx;
        rx_pause = calm_rx ? 0 : $urandom_range(0, 5);
        if (results_taken == 60 || results_taken == 300) rx_pause = 80;
      end
      if (rx_pause > 0) begin
        result_stall <= 1'b1;
        rx_pause--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("io_instruction_exit_info_decoder test failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic [15:0] dx, input bit fixed = 1'b0,
                           input result_t want = '0);
    int gap;
    result_t r;
    gap = calm_tx ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= {b, dx};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    if (decode_byte(item_t'({b, dx}), r)) expected_exits.push_back(fixed ? want : r);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (expected_exits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode_q = m;
    dec = restart(m);
  endtask

  function automatic logic [15:0] pick_dx();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_prefix();
    if ($urandom_range(0, 4) == 0) return {REX_HIGH, 4'($urandom)};
    return prefix_set[$urandom_range(0, 9)];
  endfunction

  task automatic send_instruction();
    int n;
    logic [7:0] op;
    if ($urandom_range(0, 49) == 0) calm_tx = ~calm_tx;
    if ($urandom_range(0, 99) < 12) begin
      send_byte(8'($urandom), pick_dx());
      return;
    end
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 18) : $urandom_range(0, 3);
    repeat (n) send_byte(pick_prefix(), pick_dx());
    if ($urandom_range(0, 4) == 0) begin
      op = 8'($urandom);
    end else if ($urandom_range(0, 1) == 0) begin
      op = OP_IMM_LOW + 8'($urandom_range(0, 3));
    end else begin
      op = OP_DX_LOW + 8'($urandom_range(0, 3));
    end
    send_byte(op, pick_dx());
    if (op >= OP_IMM_LOW && op <= OP_IMM_HIGH) send_byte(8'($urandom), pick_dx());
  endtask

  initial begin
    mode_q = MODE_LONG;
    dec = restart(MODE_LONG);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (plan[i]) send_byte(plan[i].code, plan[i].dx, plan[i].fixed, plan[i].want);
    foreach (mode_plan[p]) begin
      drain();
      write_mode(mode_plan[p]);
      items_sent = 0;
      while (items_sent < ITEMS_PER_MODE) send_instruction();
    end
    drain();
    if (mismatches == 0) begin
      $display("io_instruction_exit_info_decoder test passed");
    end else begin
      $display("io_instruction_exit_info_decoder test failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/iied_pkg.sv
hw/rtl/iied_decoder.sv
hw/rtl/iied_out_reg.sv
hw/rtl/io_instruction_exit_info_decoder.sv
dv/tb_io_instruction_exit_info_decoder.sv
